// ----- hdl/assert_macros.svh -----
// assertion macros shared by the ordered set table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_ON_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// concurrent assertion on the local clk_i and rst_ni
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_ON_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- hdl/ost_pkg.sv -----
// types and codes for the ordered set table
`timescale 1ns / 1ps

package ost_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TEST   = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [31:0] key;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic        found;
    status_e     status;
    logic [3:0]  hit_position;
    logic [31:0] read_key;
    logic [4:0]  entry_count;
  } rsp_t;

  // operation strobes broadcast along the cell row
  typedef struct packed {
    logic append;
    logic remove;
  } chain_ctl_t;

endpackage

// ----- hdl/ost_cell.sv -----
// one table cell: holds a key, compares it and takes its right neighbor on removal
`timescale 1ns / 1ps

module ost_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [KEY_WIDTH-1:0] nbr_i,
  input  logic                 occupied_i,
  input  logic                 write_i,
  input  logic                 shift_i,
  output logic                 match_o,
  output logic [KEY_WIDTH-1:0] entry_o
);

  logic [KEY_WIDTH-1:0] entry_q;
  logic [KEY_WIDTH-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (write_i) begin
      entry_d = key_i;
    end else if (shift_i) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign match_o = occupied_i & (entry_q == key_i);
  assign entry_o = entry_q;

endmodule

// ----- hdl/ost_chain.sv -----
// row of table cells with match encoding and position read-out
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ost_chain #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32,
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int IW       = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ost_pkg::chain_ctl_t    ctl_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [CW-1:0]          count_i,
  input  logic [IW-1:0]          rd_idx_i,
  output logic                   found_o,
  output logic [IW-1:0]          hit_idx_o,
  output logic [KEY_WIDTH-1:0]   rd_key_o
);

  logic [DEPTH-1:0]     match;
  logic [KEY_WIDTH-1:0] entry_w [DEPTH];
  logic [KEY_WIDTH-1:0] nbr_w   [DEPTH];
  logic [DEPTH-1:0]     write_w;
  logic [DEPTH-1:0]     shift_w;
  logic [DEPTH-1:0]     occ_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] CIDX = CW'(i);
    localparam logic [IW-1:0] PIDX = IW'(i);

    assign occ_w[i]   = (CIDX < count_i);
    // append lands in the first free cell, removal pulls down everything from the hit on
    assign write_w[i] = ctl_i.append & ~found_o & (count_i == CIDX);
    assign shift_w[i] = ctl_i.remove & found_o & (PIDX >= hit_idx_o);

    if (i == DEPTH - 1) begin : g_last
      assign nbr_w[i] = '0;
    end else begin : g_mid
      assign nbr_w[i] = entry_w[i+1];
    end

    ost_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .key_i      (key_i),
      .nbr_i      (nbr_w[i]),
      .occupied_i (occ_w[i]),
      .write_i    (write_w[i]),
      .shift_i    (shift_w[i]),
      .match_o    (match[i]),
      .entry_o    (entry_w[i])
    );
  end

  assign found_o = |match;

  // keys are distinct so at most one match, an or of indexes encodes it
  always_comb begin
    hit_idx_o = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (match[j]) begin
        hit_idx_o = hit_idx_o | IW'(j);
      end
    end
  end

  always_comb begin
    rd_key_o = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (rd_idx_i == IW'(j)) begin
        rd_key_o = rd_key_o | entry_w[j];
      end
    end
  end

  `ASSERT_DEF(a_match_onehot, $onehot0(match), "stored keys are not distinct")
  `ASSERT_DEF(a_no_write_shift, (write_w & shift_w) == '0, "cell written and shifted at once")

endmodule

// ----- hdl/ordered_set_table.sv -----
// ordered set table: one request per cycle unless stalled, result registered on acceptance
// throughput: 1 request per cycle when not stalled, set by compare and shift across the cell row
// input stalls only while a finished result is held and the output side stalls
// reset clears the entry count and the output valid, stored keys keep no reset value
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ordered_set_table #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ost_pkg::req_t    in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ost_pkg::rsp_t    out_rsp_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > 4) ? CW : 4;
  localparam int HW = (IW > 4) ? IW : 4;
  localparam int XW = (KEY_WIDTH > 32) ? KEY_WIDTH : 32;

  logic                 in_acc;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        count_d;
  logic                 out_valid_q;
  ost_pkg::rsp_t        rsp_q;
  ost_pkg::rsp_t        rsp_d;
  ost_pkg::chain_ctl_t  ctl;

  logic [XW-1:0]        key_ext;
  logic [KEY_WIDTH-1:0] key_k;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        cnt_pext;
  logic                 pos_ok;
  logic [IW-1:0]        rd_idx;
  logic                 found;
  logic [IW-1:0]        hit_idx;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [HW-1:0]        hit_ext;
  logic [HW-1:0]        cnt_hext;
  logic [XW-1:0]        rkey_ext;
  logic                 full_drop;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign key_ext  = XW'(in_req_i.key);
  assign key_k    = key_ext[KEY_WIDTH-1:0];
  assign pos_ext  = PW'(in_req_i.position);
  assign cnt_pext = PW'(count_q);
  assign pos_ok   = (pos_ext < cnt_pext);
  assign rd_idx   = pos_ext[IW-1:0];

  assign ctl.append = in_acc & (in_req_i.req_type == ost_pkg::REQ_ADD);
  assign ctl.remove = in_acc & (in_req_i.req_type == ost_pkg::REQ_REMOVE);

  ost_chain #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .key_i     (key_k),
    .count_i   (count_q),
    .rd_idx_i  (rd_idx),
    .found_o   (found),
    .hit_idx_o (hit_idx),
    .rd_key_o  (rd_key)
  );

  assign hit_ext  = HW'(hit_idx);
  assign cnt_hext = HW'(count_q[IW-1:0]);
  assign rkey_ext = XW'(rd_key);

  always_comb begin
    count_d            = count_q;
    rsp_d.found        = 1'b0;
    rsp_d.status       = ost_pkg::ST_OK;
    rsp_d.hit_position = '0;
    rsp_d.read_key     = '0;
    case (in_req_i.req_type)
      ost_pkg::REQ_READ: begin
        if (pos_ok) begin
          rsp_d.hit_position = pos_ext[3:0];
          rsp_d.read_key     = rkey_ext[31:0];
        end else begin
          rsp_d.status = ost_pkg::ST_RANGE;
        end
      end
      ost_pkg::REQ_ADD: begin
        rsp_d.found = found;
        if (found) begin
          rsp_d.status       = ost_pkg::ST_PRESENT;
          rsp_d.hit_position = hit_ext[3:0];
        end else if (count_q == CW'(DEPTH)) begin
          rsp_d.status = ost_pkg::ST_FULL;
        end else begin
          rsp_d.hit_position = cnt_hext[3:0];
          count_d            = count_q + 1'b1;
        end
      end
      ost_pkg::REQ_REMOVE: begin
        rsp_d.found = found;
        if (found) begin
          rsp_d.hit_position = hit_ext[3:0];
          count_d            = count_q - 1'b1;
        end else begin
          rsp_d.status = ost_pkg::ST_ABSENT;
        end
      end
      ost_pkg::REQ_TEST: begin
        rsp_d.found = found;
        if (found) begin
          rsp_d.hit_position = hit_ext[3:0];
        end else begin
          rsp_d.status = ost_pkg::ST_ABSENT;
        end
      end
      default: begin
        rsp_d.status = ost_pkg::ST_OK;
      end
    endcase
    rsp_d.entry_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q <= count_d;
      end
      out_valid_q <= in_acc | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign full_drop = in_acc & (rsp_d.status == ost_pkg::ST_FULL);

  `ASSERT_DEF(a_count_hold, !in_acc |=> $stable(count_q), "count moved without a transaction")
  `ASSERT_DEF(a_count_bound, count_q <= CW'(DEPTH), "count beyond table depth")
  `ASSERT_DEF(a_out_load, in_acc |=> out_valid_q, "accepted request produced no result")
  `ASSERT_DEF(a_full_drop, full_drop |=> count_q == CW'(DEPTH), "full drop changed count")

endmodule
